// ===== rtl/tfp_pkg.sv =====
// ----------------------------------------------------------------------------
// tfp_pkg
// shared types, codes and helpers of the telemetry frame parser
// ----------------------------------------------------------------------------
package tfp_pkg;

    // payload size limits and field layout
    localparam int PAYLOAD_BYTES_DEF = 18;
    localparam int DECODE_BYTES      = 18;
    localparam int COUNT_W           = 6;
    localparam int LIMIT_W           = 31;
    localparam int CFG_INDEX_W       = 2;
    localparam int CFG_DATA_W        = 31;

    // register reset values
    localparam logic [7:0]         SYNC_RESET      = 8'd170;
    localparam logic [LIMIT_W-1:0] LAT_LIMIT_RESET = 31'd1800000000;
    localparam logic [LIMIT_W-1:0] LON_LIMIT_RESET = 31'd900000000;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SYNC_VALUE = 2'd0,
        REG_LAT_LIMIT  = 2'd1,
        REG_LON_LIMIT  = 2'd2,
        REG_UNUSED     = 2'd3
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_FRAME_OK   = 2'd0,
        ST_ACCEPTED   = 2'd1,
        ST_IGNORED    = 2'd2,
        ST_CSUM_ERROR = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        PH_UNSYNCED = 3'b001,
        PH_PAYLOAD  = 3'b010,
        PH_CHECK    = 3'b100
    } phase_t;

    // true when |raw| exceeds the limit, exact integer test
    function automatic logic coord_out_of_range(input logic [31:0] raw,
                                                input logic [LIMIT_W-1:0] limit);
        logic [31:0] mag;
        mag = raw[31] ? (~raw + 32'd1) : raw;
        return mag > {1'b0, limit};
    endfunction

endpackage

// ===== rtl/telemetry_frame_parser.sv =====
// ----------------------------------------------------------------------------
// telemetry_frame_parser
// byte-wise framing, checksum and field decode of a serial telemetry stream
// ----------------------------------------------------------------------------
// one received byte enters per request on in_valid/in_ready (rx_byte)
// every byte gives exactly one result on out_valid/out_ready: a status and
// the held field values (latitude, longitude, altitude, ground_speed,
// aux_word, battery_level)
// the result of a byte is registered and is shown from the clock edge
// that takes the byte
// throughput is one byte per cycle while results are taken; the single
// result register is the only buffer, so in_ready follows !out_valid || out_ready
// when the receiver stalls the result holds and no more bytes are taken
// config writes (cfg_valid/cfg_ready, cfg_index, cfg_data) are always
// taken, as cfg_ready is tied high, and are meant for an idle block
// reset brings the parser to unsynced, clears the running sum, byte count
// and all held values, and loads the default sync byte and limits
// ----------------------------------------------------------------------------
module telemetry_frame_parser
    import tfp_pkg::*;
#(
    parameter int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,

    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [7:0]             rx_byte,

    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [1:0]             status,
    output logic signed [31:0]     latitude,
    output logic signed [31:0]     longitude,
    output logic signed [31:0]     altitude,
    output logic [15:0]            ground_speed,
    output logic [15:0]            aux_word,
    output logic [15:0]            battery_level
);

    logic [7:0]         sync_value_reg;
    logic [LIMIT_W-1:0] lat_limit_reg;
    logic [LIMIT_W-1:0] lon_limit_reg;

    phase_t             phase_reg, phase_next;
    logic [COUNT_W-1:0] byte_count_reg, byte_count_next;
    logic [7:0]         sum_reg, sum_next;
    logic [7:0]         store_reg [DECODE_BYTES];

    logic               out_valid_reg;
    status_t            status_reg, status_next;
    logic [31:0]        lat_reg, lon_reg, alt_reg;
    logic [15:0]        speed_reg, aux_reg, batt_reg;

    logic               accept;
    logic               frame_ok;
    logic [COUNT_W-1:0] count_inc;
    logic [31:0]        raw_lat, raw_lon;

    assign cfg_ready = 1'b1;
    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;

    assign count_inc = byte_count_reg + COUNT_W'(1);
    assign raw_lat   = {store_reg[3], store_reg[2], store_reg[1], store_reg[0]};
    assign raw_lon   = {store_reg[7], store_reg[6], store_reg[5], store_reg[4]};

    always_comb
    begin
        phase_next      = phase_reg;
        byte_count_next = byte_count_reg;
        sum_next        = sum_reg;
        status_next     = ST_ACCEPTED;
        frame_ok        = 1'b0;
        unique case (phase_reg)
            PH_PAYLOAD:
            begin
                sum_next        = sum_reg + rx_byte;
                byte_count_next = count_inc;
                if (count_inc >= COUNT_W'(PAYLOAD_BYTES))
                begin
                    phase_next = PH_CHECK;
                end
            end
            PH_CHECK:
            begin
                // checksum byte is always consumed, never taken as sync
                if (rx_byte == sum_reg)
                begin
                    frame_ok    = 1'b1;
                    status_next = ST_FRAME_OK;
                end
                else
                begin
                    status_next = ST_CSUM_ERROR;
                end
                phase_next = PH_UNSYNCED;
            end
            default:
            begin
                if (rx_byte == sync_value_reg)
                begin
                    byte_count_next = '0;
                    sum_next        = rx_byte;
                    phase_next      = PH_PAYLOAD;
                end
                else
                begin
                    phase_next  = PH_UNSYNCED;
                    status_next = ST_IGNORED;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_value_reg <= SYNC_RESET;
            lat_limit_reg  <= LAT_LIMIT_RESET;
            lon_limit_reg  <= LON_LIMIT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_SYNC_VALUE: sync_value_reg <= cfg_data[7:0];
                REG_LAT_LIMIT:  lat_limit_reg  <= cfg_data[LIMIT_W-1:0];
                REG_LON_LIMIT:  lon_limit_reg  <= cfg_data[LIMIT_W-1:0];
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_UNSYNCED;
            byte_count_reg <= '0;
            sum_reg        <= '0;
            out_valid_reg  <= 1'b0;
            status_reg     <= ST_ACCEPTED;
            lat_reg        <= '0;
            lon_reg        <= '0;
            alt_reg        <= '0;
            speed_reg      <= '0;
            aux_reg        <= '0;
            batt_reg       <= '0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg      <= phase_next;
                byte_count_reg <= byte_count_next;
                sum_reg        <= sum_next;
                status_reg     <= status_next;
                out_valid_reg  <= 1'b1;
                if (frame_ok)
                begin
                    lat_reg   <= coord_out_of_range(raw_lat, lat_limit_reg) ? '0 : raw_lat;
                    lon_reg   <= coord_out_of_range(raw_lon, lon_limit_reg) ? '0 : raw_lon;
                    alt_reg   <= {store_reg[11], store_reg[10], store_reg[9], store_reg[8]};
                    speed_reg <= {store_reg[13], store_reg[12]};
                    aux_reg   <= {store_reg[15], store_reg[14]};
                    batt_reg  <= {store_reg[17], store_reg[16]};
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // only the decoded head of the payload is kept; later bytes are summed only
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < DECODE_BYTES; i++)
        begin
            if (accept && phase_reg == PH_PAYLOAD && byte_count_reg == COUNT_W'(i))
            begin
                store_reg[i] <= rx_byte;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign latitude      = lat_reg;
    assign longitude     = lon_reg;
    assign altitude      = alt_reg;
    assign ground_speed  = speed_reg;
    assign aux_word      = aux_reg;
    assign battery_level = batt_reg;

endmodule

// ===== rtl/tfp_checker.sv =====
// ----------------------------------------------------------------------------
// tfp_port_checks
// port-level checks of the telemetry frame parser
// ----------------------------------------------------------------------------
module tfp_port_checks
    import tfp_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic [1:0]         status,
    input logic signed [31:0] latitude,
    input logic signed [31:0] altitude,
    input logic [15:0]        battery_level
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status))
        else $error("result changed while stalled");

    // every request gives a result in the following cycle
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("missing result for request");

    // an empty result slot never blocks the input
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked with empty result slot");

    // latitude, altitude and battery level move only with a good frame
    a_held: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(latitude) || !$stable(altitude) || !$stable(battery_level)
        |-> out_valid && status == ST_FRAME_OK)
        else $error("held value changed without a good frame");

endmodule

bind telemetry_frame_parser tfp_port_checks u_tfp_port_checks (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .latitude      (latitude),
    .altitude      (altitude),
    .battery_level (battery_level)
);
